>>> hdl/d2s_pkg.sv
package d2s_pkg;

  localparam int unsigned SecW    = 6;
  localparam int unsigned MinW    = 6;
  localparam int unsigned HourW   = 5;
  localparam int unsigned DayW    = 5;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned YearW   = 12;
  localparam int unsigned ResultW = 32;

  localparam int unsigned HmW     = 11;
  localparam int unsigned LeapW   = 10;

  localparam logic [ResultW-1:0] SecPerDay  = 32'd86400;
  localparam logic [ResultW-1:0] SecPerYear = 32'd31536000;
  localparam logic [6:0]         SecPerMin  = 7'd60;
  localparam logic [YearW-1:0]   EpochYear  = 12'd2018;
  localparam logic [LeapW-1:0]   EpochLeaps = 10'd504;
  localparam logic [MonthW-1:0]  MonthFeb   = 4'd2;

  typedef struct packed {
    logic [SecW-1:0]   sec;
    logic [MinW-1:0]   minute;
    logic [HourW-1:0]  hour;
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } date_t;

  function automatic logic [8:0] days_before_month(input logic [MonthW-1:0] month);
    logic [8:0] days;
    unique case (month)
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd59;
      4'd4:    days = 9'd90;
      4'd5:    days = 9'd120;
      4'd6:    days = 9'd151;
      4'd7:    days = 9'd181;
      4'd8:    days = 9'd212;
      4'd9:    days = 9'd243;
      4'd10:   days = 9'd273;
      4'd11:   days = 9'd304;
      4'd12:   days = 9'd334;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

endpackage

>>> hdl/d2s_if.sv
interface d2s_req_if;
  logic                            valid;
  logic                            ready;
  logic [d2s_pkg::SecW-1:0]        sec;
  logic [d2s_pkg::MinW-1:0]        minute;
  logic [d2s_pkg::HourW-1:0]       hour;
  logic [d2s_pkg::DayW-1:0]        day;
  logic [d2s_pkg::MonthW-1:0]      month;
  logic [d2s_pkg::YearW-1:0]       year;

  modport source (output valid, sec, minute, hour, day, month, year, input ready);
  modport sink   (input valid, sec, minute, hour, day, month, year, output ready);
endinterface

interface d2s_res_if;
  logic                            valid;
  logic                            ready;
  logic [d2s_pkg::ResultW-1:0]     seconds_since_epoch;

  modport source (output valid, seconds_since_epoch, input ready);
  modport sink   (input valid, seconds_since_epoch, output ready);
endinterface

>>> hdl/d2s_core.sv
module d2s_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  d2s_pkg::date_t              date_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [d2s_pkg::ResultW-1:0] current_o
);

  // input register
  logic                        v_q;
  d2s_pkg::date_t              date_q;

  logic [d2s_pkg::LeapW-1:0]   leaps;
  logic                        leap_extra;
  logic [d2s_pkg::YearW-1:0]   year_m1;
  logic [d2s_pkg::ResultW-1:0] daycnt;
  logic [d2s_pkg::ResultW-1:0] ydiff;
  logic [d2s_pkg::HmW-1:0]     hm;

  assign ready_o = !v_q || ready_i;
  assign valid_o = v_q;

  always_comb begin
    year_m1    = date_q.year - 12'd1;
    leaps      = (date_q.year <= d2s_pkg::EpochYear) ? '0
               : (year_m1[d2s_pkg::YearW-1:2] - d2s_pkg::EpochLeaps);
    leap_extra = (date_q.year[1:0] == 2'd0) && (date_q.month > d2s_pkg::MonthFeb);
    daycnt     = 32'(date_q.day) - 32'd1
               + 32'(d2s_pkg::days_before_month(date_q.month))
               + 32'(leap_extra) + 32'(leaps);
    ydiff      = 32'(date_q.year) - 32'(d2s_pkg::EpochYear);
    hm         = 11'(date_q.minute) + 11'(date_q.hour * 11'(d2s_pkg::SecPerMin));
    current_o  = 32'(daycnt * d2s_pkg::SecPerDay)
               + 32'(ydiff * d2s_pkg::SecPerYear)
               + 32'(32'(hm) * 32'(d2s_pkg::SecPerMin))
               + 32'(date_q.sec);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      date_q <= date_i;
    end
  end

endmodule

>>> hdl/date_to_seconds_since_2018_top.sv
// channel | dir | fields
// req_i   | in  | sec, minute, hour, day, month, year
// res_o   | out | seconds_since_epoch
//
// A request is registered in the input register when it is accepted, and its
// result is loaded into the output register once that register can take it.
// One request per cycle sustained while res_o is ready.
// One combinational pass of constant multiplies and the max compare sits
// between the input register and the output register, where the running
// maximum is kept.
// Reset clears both valid flags and the running maximum to zero.
// A stalled result holds the output register, then the input register;
// ready falls only when both are full.
module date_to_seconds_since_2018_top (
  input  logic     clk_i,
  input  logic     rst_ni,
  d2s_req_if.sink  req_i,
  d2s_res_if.source res_o
);

  d2s_pkg::date_t              date;
  logic                        core_valid;
  logic                        core_ready;
  logic [d2s_pkg::ResultW-1:0] current;
  logic                        out_valid_q;
  logic [d2s_pkg::ResultW-1:0] largest_q;

  assign date.sec    = req_i.sec;
  assign date.minute = req_i.minute;
  assign date.hour   = req_i.hour;
  assign date.day    = req_i.day;
  assign date.month  = req_i.month;
  assign date.year   = req_i.year;

  d2s_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (req_i.valid),
    .ready_o   (req_i.ready),
    .date_i    (date),
    .valid_o   (core_valid),
    .ready_i   (core_ready),
    .current_o (current)
  );

  assign core_ready = !out_valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      largest_q   <= '0;
    end else begin
      if (core_ready) begin
        out_valid_q <= core_valid;
      end
      if (core_ready && core_valid && (current > largest_q)) begin
        largest_q <= current;
      end
    end
  end

  assign res_o.valid               = out_valid_q;
  assign res_o.seconds_since_epoch = largest_q;

endmodule

>>> hdl/d2s_checker.sv
module d2s_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        res_valid_i,
  input logic                        res_ready_i,
  input logic [d2s_pkg::ResultW-1:0] res_seconds_i
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_seconds_i))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_seconds_i >= $past(res_seconds_i))
    else $error("result decreased");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !res_valid_i && (res_seconds_i == '0))
    else $error("result not cleared by reset");

endmodule

bind date_to_seconds_since_2018_top d2s_checker u_d2s_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .res_seconds_i (res_o.seconds_since_epoch)
);
